// ===== rtl/msc_pkg.sv =====
// shared types, sizes and latency constants for the mesi snooping cache controller
// no dependencies; imported by msc_set_logic and the top level
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int SET_BITS    = 6;
  localparam int WAYS        = 4;
  localparam int OFFSET_BITS = 5;
  localparam int SET_COUNT   = 1 << SET_BITS;
  localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int AGE_BITS    = 16;
  localparam int LAT_BITS    = 8;
  localparam int CNT_BITS    = 32;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // modeled latencies
  localparam logic [LAT_BITS-1:0] HIT_CYCLES     = LAT_BITS'(1);
  localparam logic [LAT_BITS-1:0] MEM_CYCLES     = LAT_BITS'(100);
  localparam logic [LAT_BITS-1:0] MISS_WB_CYCLES = LAT_BITS'(2 * 100);
  localparam logic [LAT_BITS-1:0] UPDATE_CYCLES  = LAT_BITS'(2);
  localparam logic [LAT_BITS-1:0] XFER_CYCLES    = LAT_BITS'((1 << OFFSET_BITS) / 2);

  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_t;

  typedef enum logic [2:0] {
    KIND_READ      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_SNOOP_RD  = 3'd2,
    KIND_SNOOP_RDX = 3'd3,
    KIND_SNOOP_UPD = 3'd4,
    KIND_DONE_RD   = 3'd5,
    KIND_DONE_RDX  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    mesi_t               mesi;
    logic [AGE_BITS-1:0] age;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

  // per-transaction outcome handed from the set logic to the top level
  typedef struct packed {
    logic                hit;
    logic [LAT_BITS-1:0] latency;
    logic                bus_needed;
    logic                bus_request;
    logic                supplies_data;
    logic                evicted;
    logic                wrote_back;
    logic                count_access;
    logic                count_miss;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/msc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/msc_set_logic.sv =====
// one-pass update of a cache set: tag match, victim choice, mesi and lru update
// depends on msc_pkg
`timescale 1ns / 1ps
`default_nettype none

module msc_set_logic import msc_pkg::*; (
  input  wire kind_t               kind,
  input  wire logic [TAG_BITS-1:0] tag,
  input  wire logic                peer_supplied,
  input  wire row_t                row_in,
  output      row_t                row_out,
  output      result_t             res
);

  logic [WAYS-1:0] match;
  logic            match_any;
  logic [WAYS-1:0] victim;
  mesi_t           match_state;
  mesi_t           victim_state;

  // age every other valid way, clear the touched one
  function automatic row_t touch_row(row_t r, logic [WAYS-1:0] t);
    row_t o;
    o = r;
    for (int i = 0; i < WAYS; i++) begin
      if (t[i]) begin
        o[i].age = '0;
      end else if (r[i].mesi != MESI_I && r[i].age != AGE_MAX) begin
        o[i].age = r[i].age + 1'b1;
      end
    end
    return o;
  endfunction

  // lowest matching valid way, one-hot
  always_comb begin
    match       = '0;
    match_any   = 1'b0;
    match_state = MESI_I;
    for (int i = 0; i < WAYS; i++) begin
      if (!match_any && row_in[i].mesi != MESI_I && row_in[i].tag == tag) begin
        match[i]    = 1'b1;
        match_any   = 1'b1;
        match_state = row_in[i].mesi;
      end
    end
  end

  // lowest invalid way, else oldest way with lowest index on ties
  always_comb begin
    logic                inv_found;
    logic                best_set;
    logic [AGE_BITS-1:0] best;
    inv_found    = 1'b0;
    best_set     = 1'b0;
    best         = '0;
    victim       = '0;
    victim_state = MESI_I;
    for (int i = 0; i < WAYS; i++) begin
      if (!inv_found) begin
        if (row_in[i].mesi == MESI_I) begin
          inv_found    = 1'b1;
          victim       = '0;
          victim[i]    = 1'b1;
          victim_state = MESI_I;
        end else if (!best_set || row_in[i].age > best) begin
          best_set     = 1'b1;
          best         = row_in[i].age;
          victim       = '0;
          victim[i]    = 1'b1;
          victim_state = row_in[i].mesi;
        end
      end
    end
  end

  always_comb begin
    row_t r;
    r       = row_in;
    res     = '0;
    case (kind)
      KIND_READ, KIND_WRITE: begin
        res.count_access = 1'b1;
        if (match_any) begin
          res.hit     = 1'b1;
          res.latency = HIT_CYCLES;
          r = touch_row(r, match);
          if (kind == KIND_WRITE) begin
            if (match_state == MESI_S) begin
              res.bus_needed  = 1'b1;
              res.bus_request = 1'b1;
            end
            for (int i = 0; i < WAYS; i++) begin
              if (match[i]) r[i].mesi = MESI_M;
            end
          end
        end else begin
          res.count_miss  = 1'b1;
          res.bus_needed  = 1'b1;
          res.bus_request = (kind == KIND_WRITE);
          res.latency     = MEM_CYCLES;
          if (victim_state != MESI_I) begin
            res.evicted = 1'b1;
            if (victim_state == MESI_M) begin
              res.wrote_back = 1'b1;
              res.latency    = MISS_WB_CYCLES;
            end
          end
          for (int i = 0; i < WAYS; i++) begin
            if (victim[i]) begin
              r[i].tag  = tag;
              r[i].mesi = (kind == KIND_WRITE) ? MESI_M : MESI_E;
            end
          end
          r = touch_row(r, victim);
        end
      end
      KIND_SNOOP_RD: begin
        if (match_any) begin
          res.hit = 1'b1;
          if (match_state == MESI_M) begin
            res.supplies_data = 1'b1;
            res.latency       = XFER_CYCLES;
          end
          for (int i = 0; i < WAYS; i++) begin
            if (match[i]) r[i].mesi = MESI_S;
          end
        end
      end
      KIND_SNOOP_RDX: begin
        if (match_any) begin
          res.hit = 1'b1;
          for (int i = 0; i < WAYS; i++) begin
            if (match[i]) r[i].mesi = MESI_I;
          end
        end
      end
      KIND_SNOOP_UPD: begin
        if (match_any && match_state == MESI_S) begin
          res.hit     = 1'b1;
          res.latency = UPDATE_CYCLES;
        end
      end
      KIND_DONE_RD, KIND_DONE_RDX: begin
        if (match_any) begin
          res.hit = 1'b1;
          for (int i = 0; i < WAYS; i++) begin
            if (match[i]) begin
              if (kind == KIND_DONE_RDX) begin
                r[i].mesi = MESI_M;
              end else if (peer_supplied) begin
                r[i].mesi = MESI_S;
              end
            end
          end
          r = touch_row(r, match);
        end
      end
      default: begin
        r = row_in;
      end
    endcase
    row_out = r;
  end

endmodule

`default_nettype wire

// ===== rtl/mesi_snooping_cache_controller.sv =====
// top level of the mesi snooping cache controller: tag store ram, set logic, counters
// depends on msc_pkg, msc_ram and msc_set_logic
`timescale 1ns / 1ps
`default_nettype none

// set-associative l1 tag store with mesi line states and counter-based lru
//
// input channel: a transaction (kind, address, peer_supplied) is taken at a
//   rising edge where start is high and busy is low. busy is high during reset
//   and until the first edge after it, then stays low, so one transaction can be
//   taken every cycle.
// output channel: done is high for exactly one cycle carrying the result of
//   one transaction; results come out in order, each transaction passing the
//   stage-one register and then the result register after its accept edge.
//   the receiver cannot stall, so nothing ever backs up.
// pipeline: the accept edge registers the transaction and launches the read
//   of its set row from the tag ram; in the next cycle the set logic updates
//   the row, the row is written back and the result and the four statistic
//   counters are registered. a row written in the previous cycle is forwarded
//   so back-to-back transactions to one set see each other.
// reset: synchronous rst clears the per-set valid bits (a set that was never
//   written reads as all-invalid lines), the counters and the pipeline.
//   no clearing pass over the ram is needed.
// kind 7 leaves the tag store alone and reports only the block address and
//   the counter totals.

module mesi_snooping_cache_controller import msc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [2:0]           kind,
  input  wire logic [ADDR_BITS-1:0] address,
  input  wire logic                 peer_supplied,
  output      logic                 done,
  output      logic                 hit,
  output      logic [LAT_BITS-1:0]  latency,
  output      logic                 bus_needed,
  output      logic                 bus_request,
  output      logic [ADDR_BITS-1:0] block_address,
  output      logic                 supplies_data,
  output      logic                 evicted,
  output      logic                 wrote_back,
  output      logic [CNT_BITS-1:0]  access_total,
  output      logic [CNT_BITS-1:0]  miss_total,
  output      logic [CNT_BITS-1:0]  eviction_total,
  output      logic [CNT_BITS-1:0]  writeback_total
);

  logic                 accept;
  logic [SET_BITS-1:0]  in_set;

  // stage one: registered transaction
  logic                 s1_valid;
  kind_t                s1_kind;
  logic [ADDR_BITS-1:0] s1_addr;
  logic                 s1_got;
  logic [SET_BITS-1:0]  s1_set;
  logic [TAG_BITS-1:0]  s1_tag;

  // tag ram and forwarding of the row written last cycle
  logic [SET_COUNT-1:0] row_valid;
  row_t                 ram_row;
  row_t                 fwd_row;
  logic                 fwd_hit;
  row_t                 row_cur;
  row_t                 row_next;
  result_t              res;

  assign accept = start && !busy;
  assign in_set = address[OFFSET_BITS +: SET_BITS];
  assign s1_set = s1_addr[OFFSET_BITS +: SET_BITS];
  assign s1_tag = s1_addr[ADDR_BITS-1 -: TAG_BITS];

  // busy only during and right after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind_t'(kind);
      s1_addr <= address;
      s1_got  <= peer_supplied;
    end
  end

  // the ram read launched at the accept edge misses the write of that same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= s1_valid && (s1_set == in_set);
    end
  end

  always_ff @(posedge clk) begin
    fwd_row <= row_next;
  end

  // a set never written since reset holds all-invalid lines
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (s1_valid) begin
      row_valid[s1_set] <= 1'b1;
    end
  end

  msc_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (SET_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_set),
    .wdata (row_next),
    .raddr (in_set),
    .rdata (ram_row)
  );

  always_comb begin
    if (fwd_hit) begin
      row_cur = fwd_row;
    end else if (row_valid[s1_set]) begin
      row_cur = ram_row;
    end else begin
      row_cur = '0;
    end
  end

  msc_set_logic u_set_logic (
    .kind          (s1_kind),
    .tag           (s1_tag),
    .peer_supplied (s1_got),
    .row_in        (row_cur),
    .row_out       (row_next),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      hit           <= res.hit;
      latency       <= res.latency;
      bus_needed    <= res.bus_needed;
      bus_request   <= res.bus_request;
      block_address <= {s1_addr[ADDR_BITS-1:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
      supplies_data <= res.supplies_data;
      evicted       <= res.evicted;
      wrote_back    <= res.wrote_back;
    end
  end

  // statistic counters, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      access_total    <= '0;
      miss_total      <= '0;
      eviction_total  <= '0;
      writeback_total <= '0;
    end else if (s1_valid) begin
      access_total    <= access_total + {{(CNT_BITS-1){1'b0}}, res.count_access};
      miss_total      <= miss_total + {{(CNT_BITS-1){1'b0}}, res.count_miss};
      eviction_total  <= eviction_total + {{(CNT_BITS-1){1'b0}}, res.evicted};
      writeback_total <= writeback_total + {{(CNT_BITS-1){1'b0}}, res.wrote_back};
    end
  end

  // every accepted transaction gives one result, through s1_valid and then done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted transaction produced no result");

  // a writeback only happens on an eviction
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    (done && wrote_back) |-> evicted)
    else $error("writeback without eviction");

  // data is only supplied on a snoop that found the line
  a_supply_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (done && supplies_data) |-> hit)
    else $error("data supplied without a matching line");

  // read exclusive is only ever requested together with a bus transaction
  a_breq_needs_bus: assert property (@(posedge clk) disable iff (rst)
    (done && bus_request) |-> bus_needed)
    else $error("bus request without bus need");

  // counters move only when a transaction is processed
  a_counters_idle: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> ($stable(access_total) && $stable(miss_total)))
    else $error("counter changed with no transaction");

endmodule

`default_nettype wire
